FILE: src/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared sizes, types and helpers for the bounded deque with remove-by-value.
// ----------------------------------------------------------------------------
package bdq_pkg;

	// queue geometry
	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W      = $clog2(DEPTH + 1);

	// port field widths
	localparam int OP_W     = 3;
	localparam int VALUE_W  = 32;
	localparam int COUNT_W  = 5;

	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [DATA_WIDTH-1:0] word_t;
	typedef logic [OP_W-1:0]       op_t;

	// operation codes
	localparam op_t OP_PUSH_FRONT = 3'd0;
	localparam op_t OP_PUSH_BACK  = 3'd1;
	localparam op_t OP_POP_FRONT  = 3'd2;
	localparam op_t OP_POP_BACK   = 3'd3;
	localparam op_t OP_REMOVE     = 3'd4;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	localparam cnt_t CNT_DEPTH = CNT_W'(DEPTH);
	localparam idx_t IDX_LAST  = IDX_W'(DEPTH - 1);

	// physical slot of logical position pos, both below DEPTH
	function automatic idx_t slot(input idx_t head, input cnt_t pos);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(head) + (CNT_W+1)'(pos);
		if (sum >= (CNT_W+1)'(DEPTH))
			sum = sum - (CNT_W+1)'(DEPTH);
		return sum[IDX_W-1:0];
	endfunction

	// circular step forward
	function automatic idx_t idx_inc(input idx_t i);
		return (i == IDX_LAST) ? '0 : i + idx_t'(1);
	endfunction

	// circular step backward
	function automatic idx_t idx_dec(input idx_t i);
		return (i == '0) ? IDX_LAST : i - idx_t'(1);
	endfunction

	// port value to stored word
	function automatic word_t word_of(input logic [VALUE_W-1:0] v);
		logic [63:0] w;
		w = 64'(v);
		return w[DATA_WIDTH-1:0];
	endfunction

	// stored word to port value
	function automatic logic [VALUE_W-1:0] value_of(input word_t d);
		logic [63:0] w;
		w = 64'(d);
		return w[VALUE_W-1:0];
	endfunction

	// occupancy to port count field
	function automatic logic [COUNT_W-1:0] count_of(input cnt_t c);
		logic [63:0] w;
		w = 64'(c);
		return w[COUNT_W-1:0];
	endfunction

endpackage

FILE: src/bdq_ram.sv
// ----------------------------------------------------------------------------
// bdq_ram
// Simple dual-port storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bdq_ram #(
	parameter int WORDS  = 16,
	parameter int ADDR_W = 4,
	parameter int DATA_W = 32
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [WORDS];

	// write port
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: src/bounded_deque_with_remove.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_remove
// Bounded double-ended queue with push/pop at both ends and remove-by-value.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries op and value; the output
//   channel (out_valid/out_ready) returns one result per transaction: status,
//   entry_count, and the front and back words (0 when the queue is empty).
//   Entries live in a single-port-read RAM; a small sequencer drives that one
//   read port and one word compare for every step of an operation.
//   Push, pop and ignored codes pass through execute, read front, read back,
//   capture back, then load the output register; when the queue ends empty
//   the read front step sets zero words and the back steps are skipped.
//   Remove-by-value adds a scan step per entry up to the match plus a shift
//   step per entry moved to close the gap, at most occupancy steps in all.
//   The single RAM read port sets the pace: one entry is read per cycle.
//   in_ready is high only while the sequencer is idle. A finished result
//   sits in the output register and the next transaction is still accepted;
//   if the receiver stalls, the sequencer holds the following result until
//   the output register frees up.
//   Reset clears head, occupancy, sequencer and output valid; the RAM
//   contents are not cleared and only written entries are ever used.
// ----------------------------------------------------------------------------
module bounded_deque_with_remove
	import bdq_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [OP_W-1:0]     op,
	input  logic [VALUE_W-1:0]  value,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          status,
	output logic [COUNT_W-1:0]  entry_count,
	output logic [VALUE_W-1:0]  front_value,
	output logic [VALUE_W-1:0]  back_value
);

	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_EXEC     = 8'b0000_0010,
		S_SCAN     = 8'b0000_0100,
		S_SHIFT    = 8'b0000_1000,
		S_RD_FRONT = 8'b0001_0000,
		S_RD_BACK  = 8'b0010_0000,
		S_CAP_BACK = 8'b0100_0000,
		S_DONE     = 8'b1000_0000
	} state_t;

	state_t  state_q, state_d;
	op_t     op_q, op_d;
	word_t   val_q, val_d;
	idx_t    head_q, head_d;
	cnt_t    occ_q, occ_d;
	idx_t    k_q, k_d;
	status_t stat_q, stat_d;
	word_t   front_q, front_d;
	word_t   back_q, back_d;

	logic    ram_we;
	idx_t    ram_waddr;
	word_t   ram_wdata;
	idx_t    ram_raddr;
	word_t   ram_rdata;

	logic                out_valid_q;
	status_t             out_status_q;
	logic [COUNT_W-1:0]  out_count_q;
	logic [VALUE_W-1:0]  out_front_q;
	logic [VALUE_W-1:0]  out_back_q;

	logic           load_out;
	logic [CNT_W:0] k_plus1;
	logic [CNT_W:0] k_plus2;
	logic [CNT_W:0] occ_wide;

	// entry storage
	bdq_ram #(
		.WORDS  (DEPTH),
		.ADDR_W (IDX_W),
		.DATA_W (DATA_WIDTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign k_plus1  = (CNT_W+1)'(k_q) + (CNT_W+1)'(1);
	assign k_plus2  = (CNT_W+1)'(k_q) + (CNT_W+1)'(2);
	assign occ_wide = (CNT_W+1)'(occ_q);

	assign in_ready = (state_q == S_IDLE);
	assign load_out = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// sequencer and shared ram/compare datapath
	always_comb begin
		state_d   = state_q;
		op_d      = op_q;
		val_d     = val_q;
		head_d    = head_q;
		occ_d     = occ_q;
		k_d       = k_q;
		stat_d    = stat_q;
		front_d   = front_q;
		back_d    = back_q;
		ram_we    = 1'b0;
		ram_waddr = head_q;
		ram_wdata = val_q;
		ram_raddr = slot(head_q, '0);

		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op_d    = op;
					val_d   = word_of(value);
					stat_d  = ST_OK;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_RD_FRONT;
				case (op_q)
					OP_PUSH_FRONT: begin
						if (occ_q == CNT_DEPTH) begin
							stat_d = ST_FULL;
						end else begin
							head_d    = idx_dec(head_q);
							ram_we    = 1'b1;
							ram_waddr = idx_dec(head_q);
							occ_d     = occ_q + cnt_t'(1);
						end
					end
					OP_PUSH_BACK: begin
						if (occ_q == CNT_DEPTH) begin
							stat_d = ST_FULL;
						end else begin
							ram_we    = 1'b1;
							ram_waddr = slot(head_q, occ_q);
							occ_d     = occ_q + cnt_t'(1);
						end
					end
					OP_POP_FRONT: begin
						if (occ_q == '0) begin
							stat_d = ST_EMPTY;
						end else begin
							head_d = idx_inc(head_q);
							occ_d  = occ_q - cnt_t'(1);
						end
					end
					OP_POP_BACK: begin
						if (occ_q == '0)
							stat_d = ST_EMPTY;
						else
							occ_d = occ_q - cnt_t'(1);
					end
					OP_REMOVE: begin
						if (occ_q == '0) begin
							stat_d = ST_NOT_FOUND;
						end else begin
							k_d       = '0;
							ram_raddr = slot(head_q, '0);
							state_d   = S_SCAN;
						end
					end
					default: begin
					end
				endcase
			end
			S_SCAN: begin
				// ram_rdata holds the entry at position k_q
				if (ram_rdata == val_q) begin
					if (k_plus1 < occ_wide) begin
						ram_raddr = slot(head_q, k_plus1[CNT_W-1:0]);
						state_d   = S_SHIFT;
					end else begin
						occ_d   = occ_q - cnt_t'(1);
						state_d = S_RD_FRONT;
					end
				end else if (k_plus1 >= occ_wide) begin
					stat_d  = ST_NOT_FOUND;
					state_d = S_RD_FRONT;
				end else begin
					k_d       = k_plus1[IDX_W-1:0];
					ram_raddr = slot(head_q, k_plus1[CNT_W-1:0]);
				end
			end
			S_SHIFT: begin
				// move entry k+1 down to k, prefetch k+2
				ram_we    = 1'b1;
				ram_waddr = slot(head_q, cnt_t'(k_q));
				ram_wdata = ram_rdata;
				k_d       = k_plus1[IDX_W-1:0];
				if (k_plus2 < occ_wide) begin
					ram_raddr = slot(head_q, k_plus2[CNT_W-1:0]);
				end else begin
					occ_d   = occ_q - cnt_t'(1);
					state_d = S_RD_FRONT;
				end
			end
			S_RD_FRONT: begin
				if (occ_q == '0) begin
					front_d = '0;
					back_d  = '0;
					state_d = S_DONE;
				end else begin
					ram_raddr = slot(head_q, '0);
					state_d   = S_RD_BACK;
				end
			end
			S_RD_BACK: begin
				front_d   = ram_rdata;
				ram_raddr = slot(head_q, occ_q - cnt_t'(1));
				state_d   = S_CAP_BACK;
			end
			S_CAP_BACK: begin
				back_d  = ram_rdata;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (load_out)
					state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			occ_q   <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			occ_q   <= occ_d;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		op_q    <= op_d;
		val_q   <= val_d;
		k_q     <= k_d;
		stat_q  <= stat_d;
		front_q <= front_d;
		back_q  <= back_d;
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_status_q <= stat_q;
			out_count_q  <= count_of(occ_q);
			out_front_q  <= value_of(front_q);
			out_back_q   <= value_of(back_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign entry_count = out_count_q;
	assign front_value = out_front_q;
	assign back_value  = out_back_q;

	// occupancy never runs past the depth
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CNT_DEPTH)
		else $error("occupancy above depth");

	// a new result only appears after the sequencer finished an item
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result without finished item");

	// accepting a transaction takes the block busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("ready held after accept");

	// a refused push reports a full queue
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q == ST_FULL) |-> out_count_q == count_of(CNT_DEPTH))
		else $error("full status with count below depth");

	// an empty result shows zero words and a zero count
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q == ST_EMPTY) |->
			(out_count_q == '0 && out_front_q == '0 && out_back_q == '0))
		else $error("empty status with data shown");

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bounded deque with remove-by-value. A short
// scripted sequence covers the empty and full edges, every operation and
// one spare op code, then biased random traffic drives the queue between empty
// and full. Every transaction is predicted by a queue-based copy of the deque
// and each returned result is compared field by field with the oldest
// prediction. Both channels idle at random, the receiver holds off for one
// long stretch, and the sender once waits for all results to drain.
// ----------------------------------------------------------------------------
module tb_top
	import bdq_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int   CLK_PERIOD   = 20;
	localparam int   RESET_CYCLES = 8;
	localparam int   RANDOM_ITEMS = 800;
	localparam int   CYCLE_LIMIT  = 200000;
	localparam int   SETTLE_CYCLES = 40;
	localparam int   IDLE_PCT     = 14;
	localparam int   HOLD_AT      = 250;
	localparam int   HOLD_CYCLES  = 300;
	localparam int   PAUSE_AT     = 400;
	localparam int   CALM_FIRST   = 500;
	localparam int   CALM_LAST    = 650;
	localparam int   RX_CALM_FROM = 1500;
	localparam int   RX_CALM_TO   = 3500;
	localparam int   MAX_REPORTS  = 40;

	// op codes the block ignores
	localparam op_t OP_SPARE0 = 3'd5;
	localparam op_t OP_SPARE1 = 3'd6;
	localparam op_t OP_SPARE2 = 3'd7;

	// traffic mix of the random part
	typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

	typedef struct packed {
		status_t              status;
		logic [COUNT_W-1:0]   count;
		logic [VALUE_W-1:0]   front;
		logic [VALUE_W-1:0]   back;
	} deque_result_t;

	typedef struct packed {
		op_t                  code;
		logic [VALUE_W-1:0]   data;
		logic                 fixed;
		status_t              status;
		logic [COUNT_W-1:0]   count;
		logic [VALUE_W-1:0]   front;
		logic [VALUE_W-1:0]   back;
	} script_row_t;

	// scripted opening; fixed rows carry their own expected result
	localparam int NUM_ROWS = 28;
	localparam script_row_t SCRIPT [NUM_ROWS] = '{
		'{OP_POP_FRONT,  32'h0000_0000, 1'b1, ST_EMPTY,     5'd0,  32'h0, 32'h0},
		'{OP_POP_BACK,   32'h0000_0000, 1'b1, ST_EMPTY,     5'd0,  32'h0, 32'h0},
		'{OP_REMOVE,     32'h0000_0000, 1'b1, ST_NOT_FOUND, 5'd0,  32'h0, 32'h0},
		'{OP_SPARE2,     32'hFFFF_FFFF, 1'b1, ST_OK,        5'd0,  32'h0, 32'h0},
		'{OP_PUSH_BACK,  32'hFFFF_FFFF, 1'b1, ST_OK,        5'd1,
			32'hFFFF_FFFF, 32'hFFFF_FFFF},
		'{OP_POP_FRONT,  32'h0000_0000, 1'b1, ST_OK,        5'd0,  32'h0, 32'h0},
		'{OP_PUSH_FRONT, 32'h0000_0000, 1'b1, ST_OK,        5'd1,  32'h0, 32'h0},
		'{OP_PUSH_BACK,  32'h1111_0001, 1'b0, ST_OK,        5'd0,  32'h0, 32'h0},
		'{OP_PUSH_FRONT, 32'h2222_0002, 1'b0, ST_OK,        5'd0,  32'h0, 32'h0},
		'{OP_PUSH_BACK,  32'h0000_0005, 1'b0, ST_OK,        5'd0,  32'h0, 32'h0},
		'{OP_PUSH_BACK,  32'h8000_0000, 1'b0, ST_OK,        5'd0,  32'h0, 32'h0},
		'{OP_PUSH_FRONT, 32'h0000_0005, 1'b0, ST_OK,        5'd0,  32'h0, 32'h0},
		'{OP_PUSH_BACK,  32'h7FFF_FFFF, 1'b0, ST_OK,        5'd0,  32'h0, 32'h0},
		'{OP_PUSH_FRONT, 32'h0000_0003, 1'b0, ST_OK,        5'd0,  32'h0, 32'h0},
		'{OP_PUSH_BACK,  32'h0000_0005, 1'b0, ST_OK,        5'd0,  32'h0, 32'h0},
		'{OP_PUSH_BACK,  32'h1234_5678, 1'b0, ST_OK,        5'd0,  32'h0, 32'h0},
		'{OP_PUSH_FRONT, 32'h0000_0004, 1'b0, ST_OK,        5'd0,  32'h0, 32'h0},
		'{OP_PUSH_BACK,  32'h0000_0006, 1'b0, ST_OK,        5'd0,  32'h0, 32'h0},
		'{OP_PUSH_FRONT, 32'h0000_0007, 1'b0, ST_OK,        5'd0,  32'h0, 32'h0},
		'{OP_PUSH_BACK,  32'h0000_0008, 1'b0, ST_OK,        5'd0,  32'h0, 32'h0},
		'{OP_PUSH_FRONT, 32'h0000_0009, 1'b0, ST_OK,        5'd0,  32'h0, 32'h0},
		'{OP_PUSH_FRONT, 32'hFFFF_FFFF, 1'b0, ST_OK,        5'd0,  32'h0, 32'h0},
		'{OP_PUSH_BACK,  32'h0000_000A, 1'b1, ST_FULL,      5'd16,
			32'hFFFF_FFFF, 32'h0000_0008},
		'{OP_REMOVE,     32'h0000_0005, 1'b0, ST_OK,        5'd0,  32'h0, 32'h0},
		'{OP_REMOVE,     32'hDEAD_BEEF, 1'b0, ST_OK,        5'd0,  32'h0, 32'h0},
		'{OP_REMOVE,     32'hFFFF_FFFF, 1'b0, ST_OK,        5'd0,  32'h0, 32'h0},
		'{OP_REMOVE,     32'h0000_0008, 1'b0, ST_OK,        5'd0,  32'h0, 32'h0},
		'{OP_REMOVE,     32'h0000_0000, 1'b0, ST_OK,        5'd0,  32'h0, 32'h0}
	};

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [OP_W-1:0]     op;
	logic [VALUE_W-1:0]  value;
	logic                out_valid;
	logic                out_ready;
	logic [1:0]          status;
	logic [COUNT_W-1:0]  entry_count;
	logic [VALUE_W-1:0]  front_value;
	logic [VALUE_W-1:0]  back_value;

	// shadow contents, front at index 0
	word_t          shadow_deque[$];
	deque_result_t  pending_results[$];
	int             mismatches = 0;
	int             accepted_items;
	int             cycle_count = 0;
	bit             sender_calm;

	bounded_deque_with_remove u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.value       (value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.entry_count (entry_count),
		.front_value (front_value),
		.back_value  (back_value)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// one line per mismatch, printing capped
	task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
		input logic [VALUE_W-1:0] want);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("[%0t] mismatch, %s: got %0h, expected %0h", $realtime, what, got,
				want);
	endtask

	// apply one operation to the shadow deque and return the result it gives
	function automatic deque_result_t apply_to_shadow(input op_t code, input word_t v);
		deque_result_t r;
		int hit;
		r.status = ST_OK;
		hit = -1;
		case (code)
			OP_PUSH_FRONT: begin
				if (shadow_deque.size() >= DEPTH)
					r.status = ST_FULL;
				else
					shadow_deque.push_front(v);
			end
			OP_PUSH_BACK: begin
				if (shadow_deque.size() >= DEPTH)
					r.status = ST_FULL;
				else
					shadow_deque.push_back(v);
			end
			OP_POP_FRONT: begin
				if (shadow_deque.size() == 0)
					r.status = ST_EMPTY;
				else
					void'(shadow_deque.pop_front());
			end
			OP_POP_BACK: begin
				if (shadow_deque.size() == 0)
					r.status = ST_EMPTY;
				else
					void'(shadow_deque.pop_back());
			end
			OP_REMOVE: begin
				// first match from the front
				for (int k = 0; k < shadow_deque.size(); k++) begin
					if (shadow_deque[k] == v) begin
						hit = k;
						break;
					end
				end
				if (hit < 0)
					r.status = ST_NOT_FOUND;
				else
					shadow_deque.delete(hit);
			end
			default: ;
		endcase
		r.count = COUNT_W'(shadow_deque.size());
		r.front = (shadow_deque.size() == 0) ? '0 : VALUE_W'(shadow_deque[0]);
		r.back  = (shadow_deque.size() == 0) ? '0 : VALUE_W'(shadow_deque[$]);
		return r;
	endfunction

	// offer one transaction and hold it until accepted
	task automatic send_op(input op_t code, input logic [VALUE_W-1:0] v, input bit fixed,
		input deque_result_t fixed_result);
		deque_result_t predicted;
		in_valid <= 1'b1;
		op       <= code;
		value    <= v;
		do
			@(posedge clk);
		while (!in_ready);
		predicted = apply_to_shadow(code, v);
		pending_results.push_back(fixed ? fixed_result : predicted);
		accepted_items++;
	endtask

	// random gap between transactions on the input side
	task automatic input_gap();
		if (!sender_calm && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	// word source: mostly a small alphabet so removes hit duplicates
	function automatic logic [VALUE_W-1:0] pick_word();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return VALUE_W'($urandom_range(0, 7));
		else if (r < 65)
			return (r[0]) ? '1 : '0;
		else
			return $urandom;
	endfunction

	// result channel checker
	always @(posedge clk) begin
		deque_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("transaction with nothing pending", VALUE_W'(entry_count),
					'0);
			end else begin
				want = pending_results.pop_front();
				if (status != want.status)
					report_mismatch("status", VALUE_W'(status), VALUE_W'(want.status));
				if (entry_count != want.count)
					report_mismatch("entry_count", VALUE_W'(entry_count),
						VALUE_W'(want.count));
				if (front_value != want.front)
					report_mismatch("front_value", front_value, want.front);
				if (back_value != want.back)
					report_mismatch("back_value", back_value, want.back);
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// receiver: random stalls, one long hold-off, one calm window
	initial begin : receiver
		int  hold_left;
		bit  held;
		hold_left = 0;
		held      = 1'b0;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held && accepted_items >= HOLD_AT) begin
				held      = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (cycle_count >= RX_CALM_FROM && cycle_count < RX_CALM_TO) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// sender: reset, scripted opening, random traffic, drain
	initial begin : sender
		deque_result_t fixed_result;
		script_row_t   row;
		op_t           spare_ops [3];
		op_t           code;
		logic [VALUE_W-1:0] data;
		mix_t          mix;
		int            mix_left;
		int            done;
		int            r;
		int            push_pct;
		int            pop_pct;

		spare_ops      = '{OP_SPARE0, OP_SPARE1, OP_SPARE2};
		accepted_items = 0;
		sender_calm    = 1'b0;
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		op       <= OP_PUSH_FRONT;
		value    <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// scripted opening
		for (int i = 0; i < NUM_ROWS; i++) begin
			row = SCRIPT[i];
			fixed_result.status = row.status;
			fixed_result.count  = row.count;
			fixed_result.front  = row.front;
			fixed_result.back   = row.back;
			send_op(row.code, row.data, row.fixed, fixed_result);
			input_gap();
		end

		// random traffic that swings between empty and full
		mix      = MIX_EVEN;
		mix_left = 0;
		done     = 0;
		while (done < RANDOM_ITEMS) begin
			if (mix_left == 0) begin
				mix      = mix_t'($urandom_range(0, 2));
				mix_left = $urandom_range(30, 60);
			end
			mix_left--;
			case (mix)
				MIX_FILL:  begin push_pct = 70; pop_pct = 20; end
				MIX_DRAIN: begin push_pct = 25; pop_pct = 50; end
				default:   begin push_pct = 45; pop_pct = 35; end
			endcase

			r = $urandom_range(0, 99);
			if ($urandom_range(0, 99) < 3) begin
				code = spare_ops[$urandom_range(0, 2)];
				data = pick_word();
			end else begin
				if (r < push_pct) begin
					code = ($urandom_range(0, 1) != 0) ? OP_PUSH_FRONT : OP_PUSH_BACK;
					data = pick_word();
				end else if (r < push_pct + pop_pct) begin
					code = ($urandom_range(0, 1) != 0) ? OP_POP_FRONT : OP_POP_BACK;
					data = pick_word();
				end else begin
					// remove mostly a word that is held, at any position
					code = OP_REMOVE;
					if (shadow_deque.size() > 0 && $urandom_range(0, 99) < 70)
						data = VALUE_W'(
							shadow_deque[$urandom_range(0, shadow_deque.size() - 1)]);
					else
						data = pick_word();
				end
				done++;
			end

			sender_calm = (done >= CALM_FIRST && done < CALM_LAST);
			send_op(code, data, 1'b0, '0);

			// once, let every result come back before going on
			if (done == PAUSE_AT && code != OP_SPARE0 && code != OP_SPARE1
				&& code != OP_SPARE2) begin
				in_valid <= 1'b0;
				while (pending_results.size() != 0) @(posedge clk);
			end
			input_gap();
		end

		// drain and let the pipeline settle
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: files.f
src/bdq_pkg.sv
src/bdq_ram.sv
src/bounded_deque_with_remove.sv
bench/tb_top.sv
